/* rtl/core/fat_cluster_chain_walker_macros.svh */
// Assertion macros for the FAT cluster chain walker.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef FAT_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT_CLUSTER_CHAIN_WALKER_MACROS_SVH
`ifndef ASSERT_OFF
`define FCW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FCW_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define FCW_ASSERT(lbl, clk, rst, prop, msg)
`define FCW_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

/* rtl/core/fcw_pkg.sv */
// Shared types and constants of the FAT cluster chain walker.
// No dependencies; imported by the interfaces, datapath, controller and top level.
package fcw_pkg;

   localparam int CMD_W       = 2;
   localparam int VALUE_W     = 32;
   localparam int CLUSTER_W   = 32;
   localparam int OFFSET_W    = 48;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_WALK  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_CAP  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_SECTOR    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTORS_PER_CLUSTER = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_SECTORS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAT_COPIES          = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTORS_PER_FAT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_CLUSTER        = 3'd5;

   typedef struct packed {
      logic clear;
      logic close;
      logic write;
      logic walk_start;
      logic read;
      logic advance;
      logic rsp_load;
      logic rsp_reject;
   } dp_cmd_type;

   typedef struct packed {
      logic closed;
      logic full;
      logic value_zero;
      logic last_link;
   } dp_status_type;

endpackage

/* rtl/core/fcw_if.sv */
// Request and result channel interfaces of the FAT cluster chain walker.
// Depends on fcw_pkg for field widths.
interface fcw_req_if;
   import fcw_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface fcw_rsp_if;
   import fcw_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CLUSTER_W-1:0]       cluster;
   logic signed [OFFSET_W-1:0] byte_offset;
   logic                       last;
   logic [STATUS_W-1:0]        status;

   modport source (output valid, output cluster, output byte_offset, output last,
                   output status, input ready);
   modport sink   (input valid, input cluster, input byte_offset, input last,
                   input status, output ready);
endinterface

/* rtl/core/fcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fcw_datapath.sv */
// Datapath: geometry registers, FAT table memory, entry count, chain cursor,
// byte offset pipeline and result register. Depends on fcw_pkg and fcw_ram.
module fcw_datapath #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_CHAIN   = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [fcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fcw_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic [fcw_pkg::VALUE_W-1:0]       req_value,
   input  fcw_pkg::dp_cmd_type               dp_cmd,
   output fcw_pkg::dp_status_type            dp_status,
   output logic [fcw_pkg::CLUSTER_W-1:0]     rsp_cluster,
   output logic signed [fcw_pkg::OFFSET_W-1:0] rsp_byte_offset,
   output logic                              rsp_last,
   output logic [fcw_pkg::STATUS_W-1:0]      rsp_status
);
   import fcw_pkg::*;

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int LINK_W  = $clog2(MAX_CHAIN + 1);

   // geometry
   logic [12:0] bps_ff, bps_in;
   logic [7:0]  spc_ff, spc_in;
   logic [15:0] rsv_ff, rsv_in;
   logic [7:0]  copies_ff, copies_in;
   logic [31:0] spf_ff, spf_in;
   logic [31:0] root_ff, root_in;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               closed_ff, closed_in;
   logic [31:0]        cur_ff, cur_in;
   logic [LINK_W-1:0]  links_ff, links_in;

   logic [47:0]        base_ff, base_in;
   logic [47:0]        sec_ff, sec_in;
   logic [36:0]        lo_ff, lo_in;
   logic [23:0]        hi_ff, hi_in;
   logic [47:0]        off_ff, off_in;

   logic [31:0]        cluster_ff, cluster_in;
   logic [47:0]        rsp_off_ff, rsp_off_in;
   logic               last_ff, last_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [39:0]        fat_area;
   logic signed [32:0] diff;
   logic signed [41:0] diff_prod;
   logic [36:0]        hi_prod;
   logic [31:0]        next_link;
   logic               more, cont, cap;

   fcw_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (dp_cmd.write),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_en   (dp_cmd.read),
      .rd_addr (cur_ff[ADDR_W-1:0]),
      .rd_data (next_link)
   );

   always_comb begin
      bps_in    = bps_ff;
      spc_in    = spc_ff;
      rsv_in    = rsv_ff;
      copies_in = copies_ff;
      spf_in    = spf_ff;
      root_in   = root_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BYTES_PER_SECTOR:    bps_in    = csr_wr_data[12:0];
            CSR_SECTORS_PER_CLUSTER: spc_in    = csr_wr_data[7:0];
            CSR_RESERVED_SECTORS:    rsv_in    = csr_wr_data[15:0];
            CSR_FAT_COPIES:          copies_in = csr_wr_data[7:0];
            CSR_SECTORS_PER_FAT:     spf_in    = csr_wr_data;
            CSR_ROOT_CLUSTER:        root_in   = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      more = cur_ff < 32'(count_ff);
      cont = more && (next_link < 32'(count_ff));
      cap  = links_ff == LINK_W'(MAX_CHAIN - 1);

      count_in  = count_ff;
      closed_in = closed_ff;
      if (dp_cmd.clear) begin
         count_in  = '0;
         closed_in = 1'b0;
      end else if (dp_cmd.close) begin
         closed_in = 1'b1;
      end else if (dp_cmd.write) begin
         count_in = count_ff + COUNT_W'(1);
      end

      cur_in   = cur_ff;
      links_in = links_ff;
      if (dp_cmd.walk_start) begin
         cur_in   = req_value;
         links_in = '0;
      end else if (dp_cmd.advance) begin
         cur_in   = next_link;
         links_in = links_ff + LINK_W'(1);
      end

      // offset pipeline: sector number, split product, recombine (mod 2^48)
      fat_area  = spf_ff * copies_ff;
      base_in   = 48'(rsv_ff) + 48'(fat_area);
      diff      = $signed({1'b0, cur_ff}) - $signed({1'b0, root_ff});
      diff_prod = diff * $signed({1'b0, spc_ff});
      sec_in    = base_ff + {{6{diff_prod[41]}}, diff_prod};
      lo_in     = sec_ff[23:0] * bps_ff;
      hi_prod   = sec_ff[47:24] * bps_ff;
      hi_in     = hi_prod[23:0];
      off_in    = {11'b0, lo_ff} + {hi_ff, 24'b0};

      cluster_in = cluster_ff;
      rsp_off_in = rsp_off_ff;
      last_in    = last_ff;
      status_in  = status_ff;
      if (dp_cmd.rsp_load) begin
         if (dp_cmd.rsp_reject) begin
            cluster_in = '0;
            rsp_off_in = '0;
            last_in    = 1'b1;
            status_in  = STATUS_FULL;
         end else begin
            cluster_in = cur_ff;
            rsp_off_in = off_ff;
            last_in    = !cont || cap;
            status_in  = (cont && cap) ? STATUS_CAP : STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff    <= 13'd512;
         spc_ff    <= 8'd8;
         rsv_ff    <= 16'd32;
         copies_ff <= 8'd2;
         spf_ff    <= 32'd1024;
         root_ff   <= 32'd2;
         count_ff  <= '0;
         closed_ff <= 1'b0;
      end else begin
         bps_ff    <= bps_in;
         spc_ff    <= spc_in;
         rsv_ff    <= rsv_in;
         copies_ff <= copies_in;
         spf_ff    <= spf_in;
         root_ff   <= root_in;
         count_ff  <= count_in;
         closed_ff <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      links_ff   <= links_in;
      base_ff    <= base_in;
      sec_ff     <= sec_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      off_ff     <= off_in;
      cluster_ff <= cluster_in;
      rsp_off_ff <= rsp_off_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
   end

   assign dp_status.closed     = closed_ff;
   assign dp_status.full       = count_ff == COUNT_W'(TABLE_DEPTH);
   assign dp_status.value_zero = req_value == '0;
   assign dp_status.last_link  = !cont || cap;

   assign rsp_cluster     = cluster_ff;
   assign rsp_byte_offset = $signed(rsp_off_ff);
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;

endmodule

/* rtl/core/fcw_ctrl.sv */
// Controller: request decode and walk sequencer, result valid register.
// Depends on fcw_pkg and fat_cluster_chain_walker_macros.svh.
`include "fat_cluster_chain_walker_macros.svh"
module fcw_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fcw_pkg::CMD_W-1:0]   req_cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output fcw_pkg::dp_cmd_type         dp_cmd,
   input  fcw_pkg::dp_status_type      dp_status
);
   import fcw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_SUM,
      ST_OUT,
      ST_REJECT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   always_comb begin
      req_ready = state_ff == ST_IDLE;
      accept    = req_valid && req_ready;
      rsp_free  = !rsp_valid_ff || rsp_ready;
      dp_cmd    = '0;
      state_in  = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_CLEAR: dp_cmd.clear = 1'b1;
                  CMD_LOAD: begin
                     if (!dp_status.closed) begin
                        if (dp_status.value_zero) begin
                           dp_cmd.close = 1'b1;
                        end else if (dp_status.full) begin
                           state_in = ST_REJECT;
                        end else begin
                           dp_cmd.write = 1'b1;
                        end
                     end
                  end
                  CMD_WALK: begin
                     dp_cmd.walk_start = 1'b1;
                     state_in          = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            dp_cmd.read = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: state_in = ST_SUM;
         ST_SUM: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_free) begin
               dp_cmd.rsp_load = 1'b1;
               if (dp_status.last_link) begin
                  state_in = ST_IDLE;
               end else begin
                  dp_cmd.advance = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_REJECT: begin
            if (rsp_free) begin
               dp_cmd.rsp_load   = 1'b1;
               dp_cmd.rsp_reject = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = dp_cmd.rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FCW_ASSERT(a_no_overwrite, clock, reset, dp_cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready), "pending result overwritten")
   `FCW_ASSERT(a_no_write_full, clock, reset, dp_cmd.write |-> !dp_status.full, "table write past depth")
   `FCW_ASSERT_NEXT(a_link_loops, clock, reset, (state_ff == ST_OUT && dp_cmd.rsp_load && !dp_status.last_link), (state_ff == ST_READ && rsp_valid_ff), "chain did not continue")
   `FCW_ASSERT_NEXT(a_reject_done, clock, reset, (state_ff == ST_REJECT && dp_cmd.rsp_load), (state_ff == ST_IDLE && rsp_valid_ff), "reject result not issued")

endmodule

/* rtl/core/fat_cluster_chain_walker.sv */
// Walk: each result passes through the table read, two multiply stages and the output load,
// and the output load waits while an earlier result is still held; clear and load
// finish in the idle state, and a full-table reject passes through a reject state.
// The result register frees the request side once the last result is loaded.
// Synchronous active-high reset restores geometry defaults and empties the table
// count; table contents stay undefined and need no clearing pass.
module fat_cluster_chain_walker #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_CHAIN   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [fcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcw_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   fcw_req_if.sink                         req_ch,
   fcw_rsp_if.source                       rsp_ch
);
   import fcw_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   fcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_cmd   (req_ch.cmd),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   fcw_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_CHAIN   (MAX_CHAIN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_value       (req_ch.value),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .rsp_cluster     (rsp_ch.cluster),
      .rsp_byte_offset (rsp_ch.byte_offset),
      .rsp_last        (rsp_ch.last),
      .rsp_status      (rsp_ch.status)
   );

endmodule

/* sim/fat_cluster_chain_walker_tb.sv */
// Self-checking testbench for fat_cluster_chain_walker: table loads, chain walks,
// cap cases under several geometry settings, with random backpressure.
// Depends on fcw_pkg and the fcw_req_if / fcw_rsp_if interfaces from the RTL.
`timescale 1ns / 100ps

module fat_cluster_chain_walker_tb;
   import fcw_pkg::*;

   localparam int          TABLE_DEPTH  = 1024;
   localparam int          MAX_CHAIN    = 64;
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   localparam int          SETTLE_TICKS = 8;

   typedef struct {
      logic [CLUSTER_W-1:0] cluster;
      logic [OFFSET_W-1:0]  offset;
      logic                 last;
      logic [STATUS_W-1:0]  status;
   } chain_link_type;

   class fat_chain_predictor;
      logic [31:0]     fat_words[TABLE_DEPTH];
      int unsigned     entry_count;
      bit              load_closed;
      logic [12:0]     bytes_per_sector;
      logic [7:0]      sectors_per_cluster;
      logic [15:0]     reserved_sectors;
      logic [7:0]      fat_copies;
      logic [31:0]     sectors_per_fat;
      logic [31:0]     root_cluster;
      chain_link_type  pending_links[$];
      int              errors;
      int              links_checked;
      int              walks;
      int              capped;
      int              rejects;

      function new();
         entry_count         = 0;
         load_closed         = 0;
         bytes_per_sector    = 13'd512;
         sectors_per_cluster = 8'd8;
         reserved_sectors    = 16'd32;
         fat_copies          = 8'd2;
         sectors_per_fat     = 32'd1024;
         root_cluster        = 32'd2;
         errors              = 0;
         links_checked       = 0;
         walks               = 0;
         capped              = 0;
         rejects             = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BYTES_PER_SECTOR:    bytes_per_sector    = data[12:0];
            CSR_SECTORS_PER_CLUSTER: sectors_per_cluster = data[7:0];
            CSR_RESERVED_SECTORS:    reserved_sectors    = data[15:0];
            CSR_FAT_COPIES:          fat_copies          = data[7:0];
            CSR_SECTORS_PER_FAT:     sectors_per_fat     = data;
            CSR_ROOT_CLUSTER:        root_cluster        = data;
            default: ;
         endcase
      endfunction

      function logic [OFFSET_W-1:0] offset_of(logic [31:0] cl);
         logic [63:0] sec;
         sec = {48'd0, reserved_sectors}
             + {32'd0, sectors_per_fat} * {56'd0, fat_copies}
             + ({32'd0, cl} - {32'd0, root_cluster}) * {56'd0, sectors_per_cluster};
         sec = sec * {51'd0, bytes_per_sector};
         return sec[OFFSET_W-1:0];
      endfunction

      function void push_link(logic [31:0] cl, logic [OFFSET_W-1:0] off, logic last,
                              logic [STATUS_W-1:0] status);
         chain_link_type e;
         e.cluster = cl;
         e.offset  = off;
         e.last    = last;
         e.status  = status;
         pending_links.insert(pending_links.size(), e);
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
         logic [31:0] cur;
         logic [31:0] next;
         bit          more;
         int          n;
         case (cmd)
            CMD_CLEAR: begin
               entry_count = 0;
               load_closed = 0;
            end
            CMD_LOAD: begin
               if (!load_closed) begin
                  if (value == 0)
                     load_closed = 1;
                  else if (entry_count >= TABLE_DEPTH) begin
                     push_link(0, 0, 1'b1, STATUS_FULL);
                     rejects++;
                  end else begin
                     fat_words[entry_count] = value;
                     entry_count++;
                  end
               end
            end
            CMD_WALK: begin
               walks++;
               cur = value;
               n = 0;
               forever begin
                  more = cur < entry_count;
                  next = more ? fat_words[cur] : 32'd0;
                  if (!(more && next < entry_count)) begin
                     push_link(cur, offset_of(cur), 1'b1, STATUS_OK);
                     break;
                  end
                  if (n + 1 >= MAX_CHAIN) begin
                     push_link(cur, offset_of(cur), 1'b1, STATUS_CAP);
                     capped++;
                     break;
                  end
                  push_link(cur, offset_of(cur), 1'b0, STATUS_OK);
                  n++;
                  cur = next;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_link(logic [31:0] cl, logic [OFFSET_W-1:0] off, logic last,
                               logic [STATUS_W-1:0] status);
         chain_link_type e;
         if (pending_links.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: cluster %h offset %h last %b status %0d",
                        cl, off, last, status);
            return;
         end
         e = pending_links.pop_front();
         links_checked++;
         if (e.cluster !== cl || e.offset !== off || e.last !== last
             || e.status !== status) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp cluster %h offset %h last %b status %0d, got %h %h %b %0d",
                        e.cluster, e.offset, e.last, e.status, cl, off, last, status);
         end
      endfunction

      function int pending();
         return pending_links.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   fcw_req_if req_ch();
   fcw_rsp_if rsp_ch();

   fat_cluster_chain_walker #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MAX_CHAIN  (MAX_CHAIN)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch)
   );

   fat_chain_predictor fat_chain = new();
   int  request_count  = 0;
   int  settings_count = 1;
   int  rsp_hold_ticks = 0;
   bit  req_calm       = 0;
   bit  rsp_calm       = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end

   task automatic send_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
      int gap;
      if ($urandom_range(0, 11) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
      fat_chain.note_request(cmd, value);
      request_count++;
   endtask

   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (fat_chain.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] bps, logic [31:0] spc, logic [31:0] resv,
                            logic [31:0] copies, logic [31:0] spf, logic [31:0] root);
      logic [CSR_INDEX_W-1:0] regs[6];
      logic [CSR_DATA_W-1:0]  vals[6];
      regs = '{CSR_BYTES_PER_SECTOR, CSR_SECTORS_PER_CLUSTER, CSR_RESERVED_SECTORS,
               CSR_FAT_COPIES, CSR_SECTORS_PER_FAT, CSR_ROOT_CLUSTER};
      vals = '{bps, spc, resv, copies, spf, root};
      quiesce();
      for (int i = 0; i < 6; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= regs[i];
         csr_wr_data <= vals[i];
         @(posedge clock);
         fat_chain.set_reg(regs[i], vals[i]);
      end
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   function automatic logic [31:0] nonzero_word();
      logic [31:0] v;
      v = $urandom;
      return (v == 0) ? 32'd1 : v;
   endfunction

   function automatic logic [31:0] pick_link(int unsigned n);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6 && n > 1)
         return $urandom_range(1, n - 1);
      else if (r < 7)
         return n;
      else if (r < 9)
         return nonzero_word();
      return 32'hFFFF_FFFF;
   endfunction

   function automatic logic [31:0] pick_start(int unsigned n);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return $urandom_range(0, n - 1);
      else if (r < 8)
         return n;
      else if (r < 9)
         return $urandom;
      return 32'hFFFF_FFFF;
   endfunction

   task automatic run_session(int unsigned n);
      send_request(CMD_CLEAR, $urandom);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_request(CMD_WALK, pick_start(n));
         if ($urandom_range(0, 15) == 0)
            send_request(CMD_UNUSED, $urandom);
         if ($urandom_range(0, 39) == 0)
            send_request(CMD_LOAD, 32'd0);
         send_request(CMD_LOAD, pick_link(n));
      end
      if ($urandom_range(0, 1)) begin
         send_request(CMD_LOAD, 32'd0);
         if ($urandom_range(0, 1))
            send_request(CMD_LOAD, nonzero_word());
      end
      repeat ($urandom_range(2, 6)) send_request(CMD_WALK, pick_start(n));
   endtask

   task automatic run_random(int items);
      int stop_at;
      stop_at = request_count + items;
      while (request_count < stop_at)
         run_session(($urandom_range(0, 7) == 0) ? $urandom_range(24, 48)
                                                 : $urandom_range(2, 16));
   endtask

   // response side: random ready gaps, calm stretches, and one-off long holds
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 11) == 0)
            rsp_calm = !rsp_calm;
         gap = rsp_calm ? 0 : $urandom_range(0, 7);
         if (rsp_hold_ticks > 0) begin
            gap = rsp_hold_ticks;
            rsp_hold_ticks = 0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         fat_chain.check_link(rsp_ch.cluster, rsp_ch.byte_offset, rsp_ch.last,
                              rsp_ch.status);
      end
   end

   initial begin
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_index    <= CSR_BYTES_PER_SECTOR;
      csr_wr_data  <= '0;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_CLEAR;
      req_ch.value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset geometry
      send_request(CMD_WALK, 32'd0);
      send_request(CMD_WALK, 32'hFFFF_FFFF);
      send_request(CMD_UNUSED, 32'hFFFF_FFFF);
      send_request(CMD_LOAD, 32'd1);
      send_request(CMD_LOAD, 32'd2);
      send_request(CMD_LOAD, 32'hFFFF_FFFF);
      send_request(CMD_LOAD, 32'd3);
      send_request(CMD_LOAD, 32'd5);
      send_request(CMD_WALK, 32'd0);
      send_request(CMD_WALK, 32'd4);
      rsp_hold_ticks = 400;
      send_request(CMD_WALK, 32'd3);
      send_request(CMD_LOAD, 32'h8000_0000);
      send_request(CMD_WALK, 32'd4);
      send_request(CMD_WALK, 32'd6);
      send_request(CMD_WALK, 32'd3);
      send_request(CMD_LOAD, 32'd0);
      send_request(CMD_LOAD, 32'd7);
      send_request(CMD_WALK, 32'd1);
      send_request(CMD_LOAD, 32'd0);
      send_request(CMD_CLEAR, 32'hFFFF_FFFF);
      send_request(CMD_WALK, 32'd0);
      send_request(CMD_LOAD, 32'h5555_5555);
      send_request(CMD_LOAD, 32'hAAAA_AAAA);
      send_request(CMD_WALK, 32'd1);
      send_request(CMD_WALK, 32'h1234_5678);

      configure(32'd4096, 32'd128, 32'd65535, 32'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      rsp_hold_ticks = 300;
      run_random(50);

      configure(32'd1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0);
      run_random(45);

      configure($urandom_range(1, 4096), $urandom_range(1, 128), $urandom_range(0, 65535),
                $urandom_range(1, 255), $urandom, $urandom_range(0, 40));
      run_random(50);

      configure(32'd512, $urandom_range(1, 128), $urandom_range(0, 65535),
                $urandom_range(1, 255), $urandom_range(0, 1 << 20), $urandom);
      run_random(45);

      quiesce();
      repeat (20) @(posedge clock);
      if (fat_chain.pending() != 0) begin
         fat_chain.errors++;
         $display("%0d expected results never arrived", fat_chain.pending());
      end
      $display("covered %0d requests over %0d geometry settings: %0d walks, %0d clusters",
               request_count, settings_count, fat_chain.walks, fat_chain.links_checked);
      $display("  %0d capped chains, %0d full-table rejects, %0d failures",
               fat_chain.capped, fat_chain.rejects, fat_chain.errors);
      if (fat_chain.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/fcw_pkg.sv
rtl/core/fcw_if.sv
rtl/core/fcw_ram.sv
rtl/core/fcw_datapath.sv
rtl/core/fcw_ctrl.sv
rtl/core/fat_cluster_chain_walker.sv
sim/fat_cluster_chain_walker_tb.sv
